// ===== sv/rci_pkg.sv =====
// Package for the ray / infinite cone intersection pipeline.
// Holds fixed-point constants and the input / result transfer structs.
// No dependencies.
`timescale 1ns / 1ps
package rci_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MUL_LAT   = 4;   // register stages through rci_mulq

    localparam logic [2:0] REG_CX  = 3'd0;
    localparam logic [2:0] REG_CY  = 3'd1;
    localparam logic [2:0] REG_CZ  = 3'd2;
    localparam logic [2:0] REG_RAD = 3'd3;
    localparam logic [2:0] REG_HGT = 3'd4;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] distance;
    } result_t;

    // Saturating add / subtract on signed 64 bit values
    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            sat_add = s[64] ? S64_MIN : S64_MAX;
        else
            sat_add = s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            sat_sub = s[64] ? S64_MIN : S64_MAX;
        else
            sat_sub = s[63:0];
    endfunction

endpackage

// ===== sv/rci_mulq.sv =====
// Pipelined signed Q-format multiply: floor(a*b / 2^F) saturated to 64 bits.
// Four 32x32 partial products over four register stages. Uses rci_pkg.
`timescale 1ns / 1ps
module rci_mulq (
    input  logic               clk,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);

    // stage 1: magnitudes and sign
    logic [63:0] ma_reg, mb_reg;
    logic        neg1_reg;
    // stage 2: partial products
    logic [63:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic        neg2_reg;
    // stage 3: assembled product
    logic [127:0] pr_reg;
    logic         neg3_reg;
    logic signed [63:0] p_reg;

    logic [127:0] pr_next;
    logic [63:0]  q;
    logic         rem_nz;
    logic signed [63:0] p_next;

    always_ff @(posedge clk)
    begin
        ma_reg   <= a[63] ? 64'(-a) : 64'(a);
        mb_reg   <= b[63] ? 64'(-b) : 64'(b);
        neg1_reg <= a[63] ^ b[63];
        ll_reg   <= 64'(ma_reg[31:0])  * 64'(mb_reg[31:0]);
        lh_reg   <= 64'(ma_reg[31:0])  * 64'(mb_reg[63:32]);
        hl_reg   <= 64'(ma_reg[63:32]) * 64'(mb_reg[31:0]);
        hh_reg   <= 64'(ma_reg[63:32]) * 64'(mb_reg[63:32]);
        neg2_reg <= neg1_reg;
        pr_reg   <= pr_next;
        neg3_reg <= neg2_reg;
        p_reg    <= p_next;
    end

    assign pr_next = {64'd0, ll_reg} + ({64'd0, lh_reg} << 32)
                   + ({64'd0, hl_reg} << 32) + ({hh_reg, 64'd0});

    // scale, round toward minus infinity, saturate
    always_comb
    begin
        q      = pr_reg[rci_pkg::FRAC_BITS +: 64];
        rem_nz = |pr_reg[rci_pkg::FRAC_BITS-1:0];
        if (|pr_reg[127:rci_pkg::FRAC_BITS+64])
            p_next = neg3_reg ? rci_pkg::S64_MIN : rci_pkg::S64_MAX;
        else if (neg3_reg)
        begin
            if (rem_nz)
                q = q + 64'd1;
            if (q == 64'd0 && rem_nz)
                p_next = rci_pkg::S64_MIN;
            else if (q >= 64'h8000_0000_0000_0000)
                p_next = rci_pkg::S64_MIN;
            else
                p_next = -$signed(q);
        end
        else if (q[63])
            p_next = rci_pkg::S64_MAX;
        else
            p_next = $signed(q);
    end

    assign p = p_reg;

endmodule

// ===== sv/ray_cone_intersect.sv =====
// Top level: ray against an infinite z-axis double cone, Q16.16 fixed point.
// Pipeline: 259 register stages on the valid path from the input transfer to done
// (slope divide 48, quadratic and discriminant 15, root 65, numerator 1, divide and output 130).
// Throughput: one ray per cycle, every cycle; busy is never raised.
// Reset: rst_n asynchronous, clears valid bits and sets the configuration registers to their reset values;
// data registers are not reset. Results are strobed by done for one cycle and cannot be stalled.
`timescale 1ns / 1ps
module ray_cone_intersect (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  rci_pkg::ray_t         ray,
    output logic                  done,
    output rci_pkg::result_t      result,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int ML  = rci_pkg::MUL_LAT; // rci_mulq latency
    localparam int QL  = 47;  // slope divider steps
    localparam int RL  = 64;  // root steps
    localparam int DL  = 128; // divide steps

    // configuration
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic [30:0]        rad_reg, hgt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= 31'd65536;
            hgt_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rci_pkg::REG_CX:  cx_reg  <= cfg_data;
                rci_pkg::REG_CY:  cy_reg  <= cfg_data;
                rci_pkg::REG_CZ:  cz_reg  <= cfg_data;
                rci_pkg::REG_RAD: rad_reg <= cfg_data[30:0];
                rci_pkg::REG_HGT: hgt_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    logic in_v;
    assign in_v = start;

    // ---- slope: q = (rad << F) / h, one quotient bit per stage ----
    localparam int QN = 31 + rci_pkg::FRAC_BITS;
    logic [QN-1:0] qn_reg [QL+1];
    logic [QN-1:0] qq_reg [QL+1];
    logic [31:0]   qr_reg [QL+1];
    logic [30:0]   qh_reg [QL+1];
    logic signed [31:0] dx_reg [QL+1];
    logic signed [31:0] dy_reg [QL+1];
    logic signed [31:0] dz_reg [QL+1];
    logic               v0_reg [QL+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i <= QL; i++) v0_reg[i] <= 1'b0;
        else
        begin
            v0_reg[0] <= in_v;
            for (int i = 1; i <= QL; i++) v0_reg[i] <= v0_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        qn_reg[0] <= {rad_reg, {rci_pkg::FRAC_BITS{1'b0}}};
        qq_reg[0] <= '0;
        qr_reg[0] <= '0;
        qh_reg[0] <= (hgt_reg == 31'd0) ? 31'd1 : hgt_reg;
        dx_reg[0] <= ray.dir_x;
        dy_reg[0] <= ray.dir_y;
        dz_reg[0] <= ray.dir_z;
        for (int i = 1; i <= QL; i++)
        begin
            logic [31:0] rr;
            rr = {qr_reg[i-1][30:0], qn_reg[i-1][QN-1]};
            qn_reg[i] <= qn_reg[i-1] << 1;
            qh_reg[i] <= qh_reg[i-1];
            if (rr >= {1'b0, qh_reg[i-1]})
            begin
                qr_reg[i] <= rr - {1'b0, qh_reg[i-1]};
                qq_reg[i] <= {qq_reg[i-1][QN-2:0], 1'b1};
            end
            else
            begin
                qr_reg[i] <= rr;
                qq_reg[i] <= {qq_reg[i-1][QN-2:0], 1'b0};
            end
            dx_reg[i] <= dx_reg[i-1];
            dy_reg[i] <= dy_reg[i-1];
            dz_reg[i] <= dz_reg[i-1];
        end
    end

    // origin minus apex, 33 bits so the difference never wraps
    logic signed [32:0] wex_reg [QL+1];
    logic signed [32:0] wey_reg [QL+1];
    logic signed [32:0] wez_reg [QL+1];
    always_ff @(posedge clk)
    begin
        wex_reg[0] <= 33'(ray.origin_x) - 33'(cx_reg);
        wey_reg[0] <= 33'(ray.origin_y) - 33'(cy_reg);
        wez_reg[0] <= 33'(ray.origin_z) - 33'(cz_reg);
        for (int i = 1; i <= QL; i++)
        begin
            wex_reg[i] <= wex_reg[i-1];
            wey_reg[i] <= wey_reg[i-1];
            wez_reg[i] <= wez_reg[i-1];
        end
    end

    // ---- multiply layer 1: products and k ----
    logic signed [63:0] e_x, e_y, e_z, d_x, d_y, d_z, qv;
    assign e_x = 64'(wex_reg[QL]);
    assign e_y = 64'(wey_reg[QL]);
    assign e_z = 64'(wez_reg[QL]);
    assign d_x = 64'(dx_reg[QL]);
    assign d_y = 64'(dy_reg[QL]);
    assign d_z = 64'(dz_reg[QL]);
    assign qv  = 64'(qq_reg[QL]);

    logic signed [63:0] m_dxdx, m_dydy, m_dzdz, m_dxex, m_dyey, m_dzez;
    logic signed [63:0] m_exex, m_eyey, m_ezez, m_k;
    rci_mulq u_m0 (.clk(clk), .a(d_x), .b(d_x), .p(m_dxdx));
    rci_mulq u_m1 (.clk(clk), .a(d_y), .b(d_y), .p(m_dydy));
    rci_mulq u_m2 (.clk(clk), .a(d_z), .b(d_z), .p(m_dzdz));
    rci_mulq u_m3 (.clk(clk), .a(d_x), .b(e_x), .p(m_dxex));
    rci_mulq u_m4 (.clk(clk), .a(d_y), .b(e_y), .p(m_dyey));
    rci_mulq u_m5 (.clk(clk), .a(d_z), .b(e_z), .p(m_dzez));
    rci_mulq u_m6 (.clk(clk), .a(e_x), .b(e_x), .p(m_exex));
    rci_mulq u_m7 (.clk(clk), .a(e_y), .b(e_y), .p(m_eyey));
    rci_mulq u_m8 (.clk(clk), .a(e_z), .b(e_z), .p(m_ezez));
    rci_mulq u_m9 (.clk(clk), .a(qv),  .b(qv),  .p(m_k));

    // register sums of the planar terms alongside layer 2
    logic signed [63:0] sa_reg [ML+1];
    logic signed [63:0] sb_reg [ML+1];
    logic signed [63:0] sc_reg [ML+1];
    logic               v1_reg [2*ML+1];
    always_ff @(posedge clk)
    begin
        sa_reg[0] <= rci_pkg::sat_add(m_dxdx, m_dydy);
        sb_reg[0] <= rci_pkg::sat_add(m_dxex, m_dyey);
        sc_reg[0] <= rci_pkg::sat_add(m_exex, m_eyey);
        for (int i = 1; i <= ML; i++)
        begin
            sa_reg[i] <= sa_reg[i-1];
            sb_reg[i] <= sb_reg[i-1];
            sc_reg[i] <= sc_reg[i-1];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i <= 2 * ML; i++) v1_reg[i] <= 1'b0;
        else
        begin
            v1_reg[0] <= v0_reg[QL];
            for (int i = 1; i <= 2 * ML; i++) v1_reg[i] <= v1_reg[i-1];
        end
    end

    // ---- multiply layer 2: times k (inputs registered) ----
    logic signed [63:0] zz_reg, zd_reg, ze_reg, k_reg;
    always_ff @(posedge clk)
    begin
        zz_reg <= m_dzdz;
        zd_reg <= m_dzez;
        ze_reg <= m_ezez;
        k_reg  <= m_k;
    end
    logic signed [63:0] t_a, t_b, t_c;
    rci_mulq u_k0 (.clk(clk), .a(zz_reg), .b(k_reg), .p(t_a));
    rci_mulq u_k1 (.clk(clk), .a(zd_reg), .b(k_reg), .p(t_b));
    rci_mulq u_k2 (.clk(clk), .a(ze_reg), .b(k_reg), .p(t_c));

    // sums: sa_reg[ML] and t_a both line up with v1_reg[2*ML]
    logic signed [63:0] a_reg, b_reg, c_reg;
    logic               v2_reg;
    logic signed [63:0] bt;
    assign bt = rci_pkg::sat_sub(sb_reg[ML], t_b);
    always_ff @(posedge clk)
    begin
        a_reg <= rci_pkg::sat_sub(sa_reg[ML], t_a);
        b_reg <= rci_pkg::sat_add(bt, bt);
        c_reg <= rci_pkg::sat_sub(sc_reg[ML], t_c);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg[2*ML];
    end

    // ---- multiply layer 3: B^2 and A*C ----
    logic signed [63:0] m_bb, m_ac;
    rci_mulq u_bb (.clk(clk), .a(b_reg), .b(b_reg), .p(m_bb));
    rci_mulq u_ac (.clk(clk), .a(a_reg), .b(c_reg), .p(m_ac));
    logic signed [63:0] a3_reg [ML];
    logic signed [63:0] b3_reg [ML];
    logic               v3_reg [ML];
    always_ff @(posedge clk)
    begin
        a3_reg[0] <= a_reg;
        b3_reg[0] <= b_reg;
        for (int i = 1; i < ML; i++)
        begin
            a3_reg[i] <= a3_reg[i-1];
            b3_reg[i] <= b3_reg[i-1];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < ML; i++) v3_reg[i] <= 1'b0;
        else
        begin
            v3_reg[0] <= v2_reg;
            for (int i = 1; i < ML; i++) v3_reg[i] <= v3_reg[i-1];
        end
    end

    logic signed [63:0] ac2, ac4;
    assign ac2 = rci_pkg::sat_add(m_ac, m_ac);
    assign ac4 = rci_pkg::sat_add(ac2, ac2);

    logic signed [63:0] dd_reg, a4_reg, b4_reg;
    logic               v4_reg;
    always_ff @(posedge clk)
    begin
        dd_reg <= rci_pkg::sat_sub(m_bb, ac4);
        a4_reg <= a3_reg[ML-1];
        b4_reg <= b3_reg[ML-1];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= v3_reg[ML-1];
    end

    // ---- square root of D << F, one result bit per stage ----
    // restoring method on a 128-bit radicand with 66-bit remainder
    logic [127:0] rn_reg [RL+1];
    logic [65:0]  rm_reg [RL+1];
    logic [63:0]  rs_reg [RL+1];
    logic signed [63:0] ra_reg [RL+1];
    logic signed [63:0] rb_reg [RL+1];
    logic               rmiss_reg [RL+1];
    logic               rv_reg [RL+1];

    always_ff @(posedge clk)
    begin
        rn_reg[0]    <= {{(64-rci_pkg::FRAC_BITS){dd_reg[63]}}, dd_reg,
                         {rci_pkg::FRAC_BITS{1'b0}}};
        rm_reg[0]    <= '0;
        rs_reg[0]    <= '0;
        ra_reg[0]    <= a4_reg;
        rb_reg[0]    <= b4_reg;
        rmiss_reg[0] <= dd_reg[63] || (a4_reg == 64'sd0);
        for (int i = 1; i <= RL; i++)
        begin
            logic [65:0] rr;
            logic [65:0] tt;
            rr = {rm_reg[i-1][63:0], rn_reg[i-1][127:126]};
            tt = {rs_reg[i-1], 2'b01};
            rn_reg[i] <= rn_reg[i-1] << 2;
            if (rr >= tt)
            begin
                rm_reg[i] <= rr - tt;
                rs_reg[i] <= {rs_reg[i-1][62:0], 1'b1};
            end
            else
            begin
                rm_reg[i] <= rr;
                rs_reg[i] <= {rs_reg[i-1][62:0], 1'b0};
            end
            ra_reg[i]    <= ra_reg[i-1];
            rb_reg[i]    <= rb_reg[i-1];
            rmiss_reg[i] <= rmiss_reg[i-1];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i <= RL; i++) rv_reg[i] <= 1'b0;
        else
        begin
            rv_reg[0] <= v4_reg;
            for (int i = 1; i <= RL; i++) rv_reg[i] <= rv_reg[i-1];
        end
    end

    // ---- numerator and denominator ----
    logic signed [63:0] sq, nb, num_reg, den_reg;
    logic               nmiss_reg, nv_reg;
    assign sq = $signed(rs_reg[RL]);
    assign nb = (rb_reg[RL] == rci_pkg::S64_MIN) ? rci_pkg::S64_MAX : -rb_reg[RL];
    always_ff @(posedge clk)
    begin
        num_reg   <= ra_reg[RL][63] ? rci_pkg::sat_add(nb, sq) : rci_pkg::sat_sub(nb, sq);
        den_reg   <= rci_pkg::sat_add(ra_reg[RL], ra_reg[RL]);
        nmiss_reg <= rmiss_reg[RL];
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) nv_reg <= 1'b0;
        else        nv_reg <= rv_reg[RL];
    end

    // ---- divide (|num| << F) / |den|, one quotient bit per stage ----
    logic [127:0] dn_reg [DL+1];
    logic [127:0] dq_reg [DL+1];
    logic [63:0]  dr_reg [DL+1];
    logic [63:0]  dd_den_reg [DL+1];
    logic         dneg_reg [DL+1];
    logic         dmiss_reg [DL+1];
    logic         dv_reg [DL+1];
    logic [63:0]  un, ud;
    assign un = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
    assign ud = den_reg[63] ? 64'(-den_reg) : 64'(den_reg);

    always_ff @(posedge clk)
    begin
        dn_reg[0]     <= {64'd0, un} << rci_pkg::FRAC_BITS;
        dq_reg[0]     <= '0;
        dr_reg[0]     <= '0;
        dd_den_reg[0] <= ud;
        dneg_reg[0]   <= num_reg[63] ^ den_reg[63];
        dmiss_reg[0]  <= nmiss_reg;
        for (int i = 1; i <= DL; i++)
        begin
            logic [64:0] rr;
            rr = {dr_reg[i-1], dn_reg[i-1][127]};
            dn_reg[i] <= dn_reg[i-1] << 1;
            if (rr >= {1'b0, dd_den_reg[i-1]})
            begin
                dr_reg[i] <= 64'(rr - {1'b0, dd_den_reg[i-1]});
                dq_reg[i] <= {dq_reg[i-1][126:0], 1'b1};
            end
            else
            begin
                dr_reg[i] <= rr[63:0];
                dq_reg[i] <= {dq_reg[i-1][126:0], 1'b0};
            end
            dd_den_reg[i] <= dd_den_reg[i-1];
            dneg_reg[i]   <= dneg_reg[i-1];
            dmiss_reg[i]  <= dmiss_reg[i-1];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i <= DL; i++) dv_reg[i] <= 1'b0;
        else
        begin
            dv_reg[0] <= nv_reg;
            for (int i = 1; i <= DL; i++) dv_reg[i] <= dv_reg[i-1];
        end
    end

    // ---- saturate and present ----
    logic [127:0]       qf;
    logic signed [31:0] dist_next;
    assign qf = dq_reg[DL];
    always_comb
    begin
        if (dneg_reg[DL])
            dist_next = (qf > 128'h8000_0000) ? 32'sh8000_0000 : 32'(-qf[31:0]);
        else
            dist_next = (qf > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qf[31:0]);
    end

    logic               done_reg;
    rci_pkg::result_t   res_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= dv_reg[DL];
    end
    always_ff @(posedge clk)
    begin
        res_reg.hit      <= !dmiss_reg[DL];
        res_reg.distance <= dmiss_reg[DL] ? 32'sd0 : dist_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
